[hdl/bpc_pkg.sv]
`default_nettype none

package bpc_pkg;

    // hold counter width used when the top level is not overridden
    localparam int COUNT_BITS_DEFAULT = 16;

    // threshold register
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd250;

    // configuration port
    localparam int ADDR_W = 1;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_LONG_PRESS_TICKS = 1'b0;

    // event codes
    localparam int EV_W = 2;
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

endpackage

`default_nettype wire

[hdl/bpc_button.sv]
`default_nettype none

module bpc_button #(
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          pressed,
    input  wire logic [bpc_pkg::THR_W-1:0]     long_press_ticks,
    output logic      [bpc_pkg::EV_W-1:0]      press_event
);

    localparam int CMP_W = (COUNT_BITS > bpc_pkg::THR_W) ? COUNT_BITS : bpc_pkg::THR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  down_reg;
    logic                  down_next;
    logic                  long_sent_reg;
    logic                  long_sent_next;
    logic [COUNT_BITS-1:0] hold_count_reg;
    logic [COUNT_BITS-1:0] hold_count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      thr_ext;

    // saturating increment
    assign count_inc = (hold_count_reg == COUNT_MAX) ? hold_count_reg
                                                     : hold_count_reg + COUNT_BITS'(1);
    assign count_ext = CMP_W'(count_inc);
    assign thr_ext   = CMP_W'(long_press_ticks);

    always_comb
    begin
        down_next       = down_reg;
        long_sent_next  = long_sent_reg;
        hold_count_next = hold_count_reg;
        press_event     = bpc_pkg::EV_NONE;
        if (pressed && !down_reg)
        begin
            // press edge starts a new hold
            down_next       = 1'b1;
            long_sent_next  = 1'b0;
            hold_count_next = '0;
        end
        else if (down_reg)
        begin
            hold_count_next = count_inc;
            if (pressed)
            begin
                if (!long_sent_reg && (count_ext > thr_ext))
                begin
                    long_sent_next = 1'b1;
                    press_event    = bpc_pkg::EV_LONG;
                end
            end
            else
            begin
                down_next = 1'b0;
                if (count_ext < thr_ext)
                begin
                    press_event = bpc_pkg::EV_SHORT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg       <= 1'b0;
            long_sent_reg  <= 1'b0;
            hold_count_reg <= '0;
        end
        else if (en)
        begin
            down_reg       <= down_next;
            long_sent_reg  <= long_sent_next;
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/button_press_classifier_unit.sv]
// button press classifier for two buttons (bit 0 mode, bit 1 start)
// input channel: in_valid / in_stall carrying button_bits, one sample per item
// output channel: out_valid / out_stall carrying mode_event and start_event,
//   each 0 none, 1 short press, 2 long press; every sample gives one result item
// configuration: apb-style port, long_press_ticks at byte address 0; pready is
//   always high, write only while no item is in flight
// path: an item accepted on the input goes to the output through the sample
//   register, then the result register
// throughput: one item per cycle while out_stall is low; the per-button compare
//   and saturating increment sit between the sample and result registers
// stalling: when out_stall holds a result, the sample register still takes one
//   more item; in_stall rises only once both registers are full
// reset: all hold state cleared (both buttons released), no result pending,
//   long_press_ticks back to 250
`default_nettype none

module button_press_classifier_unit #(
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    button_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [bpc_pkg::EV_W-1:0]      mode_event,
    output logic      [bpc_pkg::EV_W-1:0]      start_event,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bpc_pkg::DATA_W-1:0]    pwdata,
    output logic      [bpc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [bpc_pkg::THR_W-1:0] long_press_ticks_reg;
    logic                      sample_valid_reg;
    logic                      sample_valid_next;
    logic [1:0]                sample_reg;
    logic                      out_valid_reg;
    logic [bpc_pkg::EV_W-1:0]  mode_event_reg;
    logic [bpc_pkg::EV_W-1:0]  start_event_reg;
    logic [bpc_pkg::EV_W-1:0]  mode_ev;
    logic [bpc_pkg::EV_W-1:0]  start_ev;
    logic                      out_ready;
    logic                      advance;
    logic                      in_accept;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == bpc_pkg::ADDR_LONG_PRESS_TICKS)
                       ? bpc_pkg::DATA_W'(long_press_ticks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_ticks_reg <= bpc_pkg::THR_RESET;
        end
        else if (cfg_write && (paddr == bpc_pkg::ADDR_LONG_PRESS_TICKS))
        begin
            long_press_ticks_reg <= pwdata[bpc_pkg::THR_W-1:0];
        end
    end

    // result register free or being emptied this cycle
    assign out_ready         = !out_valid_reg || !out_stall;
    assign advance           = sample_valid_reg && out_ready;
    assign in_stall          = sample_valid_reg && !out_ready;
    assign in_accept         = in_valid && !in_stall;
    assign sample_valid_next = in_accept || (sample_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            if (out_ready)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= button_bits;
        end
        if (advance)
        begin
            mode_event_reg  <= mode_ev;
            start_event_reg <= start_ev;
        end
    end

    bpc_button #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mode (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .pressed          (sample_reg[0]),
        .long_press_ticks (long_press_ticks_reg),
        .press_event      (mode_ev)
    );

    bpc_button #(
        .COUNT_BITS (COUNT_BITS)
    ) u_start (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .pressed          (sample_reg[1]),
        .long_press_ticks (long_press_ticks_reg),
        .press_event      (start_ev)
    );

    assign out_valid   = out_valid_reg;
    assign mode_event  = mode_event_reg;
    assign start_event = start_event_reg;

endmodule

`default_nettype wire

[hdl/bpc_checker.sv]
`default_nettype none

module bpc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [bpc_pkg::EV_W-1:0]      mode_event,
    input wire logic [bpc_pkg::EV_W-1:0]      start_event,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input wire logic [bpc_pkg::DATA_W-1:0]    pwdata,
    input wire logic [bpc_pkg::DATA_W-1:0]    prdata,
    input wire logic                          pready
);

    // a held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mode_event) && $stable(start_event))
        else $error("stalled result changed");

    // an empty result register never pushes back on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // only the three event codes are ever delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_event != 2'd3) && (start_event != 2'd3))
        else $error("undefined event code");

    // a threshold write reads back
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr == bpc_pkg::ADDR_LONG_PRESS_TICKS)
        |=> (paddr != bpc_pkg::ADDR_LONG_PRESS_TICKS)
            || (prdata[bpc_pkg::THR_W-1:0] == $past(pwdata[bpc_pkg::THR_W-1:0])))
        else $error("threshold readback mismatch");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mode_event  (mode_event),
    .start_event (start_event),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);

`default_nettype wire

[tb/button_press_classifier_unit_test.sv]
`timescale 1ns / 100ps

module button_press_classifier_unit_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CNT_W = bpc_pkg::COUNT_BITS_DEFAULT;

    typedef struct packed {
        logic [bpc_pkg::EV_W-1:0] mode;
        logic [bpc_pkg::EV_W-1:0] start;
    } events_t;

    typedef struct packed {
        logic             down;
        logic             long_sent;
        logic [CNT_W-1:0] hold;
    } button_track_t;

    typedef struct packed {
        logic [bpc_pkg::THR_W-1:0] thr;
        logic [1:0]                bits;
        logic                      typed;
        logic [bpc_pkg::EV_W-1:0]  mode_ev;
        logic [bpc_pkg::EV_W-1:0]  start_ev;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   button_bits = 2'b00;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [bpc_pkg::EV_W-1:0]     mode_event;
    logic [bpc_pkg::EV_W-1:0]     start_event;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [bpc_pkg::ADDR_W-1:0]   paddr = '0;
    logic [bpc_pkg::DATA_W-1:0]   pwdata = '0;
    logic [bpc_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    events_t       pending_events[$];
    button_track_t mode_track = '0;
    button_track_t start_track = '0;
    logic [bpc_pkg::THR_W-1:0] cur_thr = bpc_pkg::THR_RESET;

    int errors = 0;
    int cycles = 0;
    int results_seen = 0;
    int burst_left = 0;
    int max_gap = 3;
    int stall_pct = 20;
    int hold_left = 0;
    bit hold_off_done = 1'b0;
    bit level[2] = '{1'b0, 1'b0};
    int run_left[2] = '{0, 0};

    // threshold steps through 250 (reset), 1, 65534 and 2
    stim_row_t directed_rows[0:18] = '{
        '{16'd250,   2'b00, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd250,   2'b11, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd250,   2'b11, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd250,   2'b00, 1'b1, bpc_pkg::EV_SHORT, bpc_pkg::EV_SHORT},
        '{16'd250,   2'b01, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd250,   2'b10, 1'b1, bpc_pkg::EV_SHORT, bpc_pkg::EV_NONE},
        '{16'd250,   2'b00, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_SHORT},
        '{16'd1,     2'b11, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b00, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b11, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b11, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b11, 1'b0, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b11, 1'b0, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd1,     2'b00, 1'b0, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd65534, 2'b10, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd65534, 2'b00, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_SHORT},
        '{16'd2,     2'b01, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd2,     2'b01, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE},
        '{16'd2,     2'b00, 1'b1, bpc_pkg::EV_NONE,  bpc_pkg::EV_NONE}
    };

    button_press_classifier_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .button_bits (button_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .mode_event  (mode_event),
        .start_event (start_event),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [bpc_pkg::EV_W-1:0] classify_button(
        inout button_track_t b,
        input logic pressed,
        input logic [bpc_pkg::THR_W-1:0] thr);
        logic [bpc_pkg::EV_W-1:0] ev;
        ev = bpc_pkg::EV_NONE;
        if (pressed && !b.down)
        begin
            b.down = 1'b1;
            b.hold = '0;
            b.long_sent = 1'b0;
        end
        else if (b.down)
        begin
            if (b.hold != '1)
                b.hold = b.hold + CNT_W'(1);
            if (pressed)
            begin
                if (!b.long_sent && b.hold > thr)
                begin
                    b.long_sent = 1'b1;
                    ev = bpc_pkg::EV_LONG;
                end
            end
            else
            begin
                b.down = 1'b0;
                if (b.hold < thr)
                    ev = bpc_pkg::EV_SHORT;
            end
        end
        return ev;
    endfunction

    // offer one sample, wait for it to be taken, then queue its events
    task automatic offer_sample(input logic [1:0] bits, input logic typed,
                                input logic [bpc_pkg::EV_W-1:0] m_ev,
                                input logic [bpc_pkg::EV_W-1:0] s_ev);
        int gap;
        events_t ev;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        button_bits <= bits;
        do
            @(posedge clk);
        while (in_stall);
        ev.mode = classify_button(mode_track, bits[0], cur_thr);
        ev.start = classify_button(start_track, bits[1], cur_thr);
        if (typed)
        begin
            ev.mode = m_ev;
            ev.start = s_ev;
        end
        pending_events.push_back(ev);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write of the threshold, then read it back
    task automatic write_threshold(input logic [bpc_pkg::THR_W-1:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= bpc_pkg::ADDR_LONG_PRESS_TICKS;
        pwdata <= {{(bpc_pkg::DATA_W-bpc_pkg::THR_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(bpc_pkg::DATA_W-bpc_pkg::THR_W){1'b0}}, value})
        begin
            $display("%0t threshold readback expected %0d actual %0d", $time, value, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        cur_thr = value;
        @(posedge clk);
    endtask

    // press runs near a threshold of 40 or less so short, exact and long holds all come up; above 40 presses are short
    task automatic random_phase(input int n_items);
        logic [1:0] bits;
        int len;
        for (int i = 0; i < n_items; i++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                if (run_left[b] == 0)
                begin
                    level[b] = !level[b];
                    if (!level[b])
                        len = $urandom_range(1, 3);
                    else if (cur_thr > 40)
                        len = $urandom_range(1, 8);
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0: len = cur_thr - 1;
                            1: len = cur_thr;
                            2: len = cur_thr + 1;
                            3: len = cur_thr + 2;
                            default: len = $urandom_range(1, 2 * cur_thr + 3);
                        endcase
                    end
                    run_left[b] = (len < 1) ? 1 : len;
                end
                run_left[b]--;
                bits[b] = level[b];
            end
            if ($urandom_range(0, 9) == 0)
                bits = 2'($urandom_range(0, 3));
            offer_sample(bits, 1'b0, bpc_pkg::EV_NONE, bpc_pkg::EV_NONE);
        end
    endtask

    always @(posedge clk)
    begin
        if (!hold_off_done && results_seen >= 200)
        begin
            hold_off_done = 1'b1;
            hold_left = 160;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        events_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_events.size() == 0)
            begin
                $display("%0t unexpected item: mode %0d start %0d", $time, mode_event,
                         start_event);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (mode_event !== want.mode)
                begin
                    $display("%0t mode_event expected %0d actual %0d", $time, want.mode,
                             mode_event);
                    errors++;
                end
                if (start_event !== want.start)
                begin
                    $display("%0t start_event expected %0d actual %0d", $time, want.start,
                             start_event);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int phase_gap[6];
        int phase_stall[6];
        logic [bpc_pkg::THR_W-1:0] phase_thr[6];
        phase_thr = '{16'd1, 16'd2, bpc_pkg::THR_W'($urandom_range(3, 8)),
                      bpc_pkg::THR_W'($urandom_range(9, 30)), 16'd65534,
                      bpc_pkg::THR_W'($urandom_range(1, 65534))};
        phase_gap = '{0, 4, 6, 2, 0, 5};
        phase_stall = '{0, 30, 70, 10, 50, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].thr != cur_thr)
                write_threshold(directed_rows[i].thr);
            offer_sample(directed_rows[i].bits, directed_rows[i].typed,
                         directed_rows[i].mode_ev, directed_rows[i].start_ev);
        end

        for (int p = 0; p < 6; p++)
        begin
            write_threshold(phase_thr[p]);
            max_gap = phase_gap[p];
            stall_pct = phase_stall[p];
            random_phase(120);
        end

        in_valid <= 1'b0;
        stall_pct = 20;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
